// ----- rtl/file_transfer_packet_parser_assert.svh -----
// ---------------------------------------------------------------------------
// file transfer packet parser assertion macros
// concurrent assertion helpers for the rtl file that checks itself
// ---------------------------------------------------------------------------
`ifndef FILE_TRANSFER_PACKET_PARSER_ASSERT_SVH
`define FILE_TRANSFER_PACKET_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FTPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FTPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ftpp_pkg.sv -----
// ---------------------------------------------------------------------------
// ftpp_pkg
// types and fixed codes of the file transfer packet parser
// ---------------------------------------------------------------------------
`default_nettype none

package ftpp_pkg;

    // byte classes
    localparam logic [2:0] CLS_KIND    = 3'd0;
    localparam logic [2:0] CLS_HEADER  = 3'd1;
    localparam logic [2:0] CLS_PAYLOAD = 3'd2;
    localparam logic [2:0] CLS_NAME    = 3'd3;
    localparam logic [2:0] CLS_SIZE    = 3'd4;
    localparam logic [2:0] CLS_TL      = 3'd5;
    localparam logic [2:0] CLS_SKIP    = 3'd6;

    // packet kinds
    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN_KIND  = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN_FIELD = 3'd2;
    localparam logic [2:0] ERR_SIZE_OVERFLOW = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED     = 3'd4;

    // register indexes
    localparam logic [2:0] REG_DATA_CODE  = 3'd0;
    localparam logic [2:0] REG_START_CODE = 3'd1;
    localparam logic [2:0] REG_END_CODE   = 3'd2;
    localparam logic [2:0] REG_SIZE_CODE  = 3'd3;
    localparam logic [2:0] REG_NAME_CODE  = 3'd4;

    // register reset values
    localparam logic [7:0] DATA_CODE_RST  = 8'd1;
    localparam logic [7:0] START_CODE_RST = 8'd2;
    localparam logic [7:0] END_CODE_RST   = 8'd3;
    localparam logic [7:0] SIZE_CODE_RST  = 8'd0;
    localparam logic [7:0] NAME_CODE_RST  = 8'd1;

    localparam int unsigned ADDR_W = 5;

    typedef struct packed {
        logic [7:0] data_code;
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] size_field_code;
        logic [7:0] name_field_code;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  byte_value;
        logic [1:0]  packet_kind;
        logic [7:0]  sequence_number;
        logic [15:0] declared_size;
        logic [31:0] file_size_value;
        logic        packet_done;
        logic [2:0]  error_code;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/ftpp_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// ftpp_cfg_regs
// apb register file holding the packet kind and field type codes
// ---------------------------------------------------------------------------
`default_nettype none

module ftpp_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ftpp_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output ftpp_pkg::cfg_t                     cfg
);
    import ftpp_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_code       <= DATA_CODE_RST;
            cfg_reg.start_code      <= START_CODE_RST;
            cfg_reg.end_code        <= END_CODE_RST;
            cfg_reg.size_field_code <= SIZE_CODE_RST;
            cfg_reg.name_field_code <= NAME_CODE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DATA_CODE:  cfg_reg.data_code       <= pwdata[7:0];
                REG_START_CODE: cfg_reg.start_code      <= pwdata[7:0];
                REG_END_CODE:   cfg_reg.end_code        <= pwdata[7:0];
                REG_SIZE_CODE:  cfg_reg.size_field_code <= pwdata[7:0];
                REG_NAME_CODE:  cfg_reg.name_field_code <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_DATA_CODE:  prdata = {24'd0, cfg_reg.data_code};
            REG_START_CODE: prdata = {24'd0, cfg_reg.start_code};
            REG_END_CODE:   prdata = {24'd0, cfg_reg.end_code};
            REG_SIZE_CODE:  prdata = {24'd0, cfg_reg.size_field_code};
            REG_NAME_CODE:  prdata = {24'd0, cfg_reg.name_field_code};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ftpp_parse_core.sv -----
// ---------------------------------------------------------------------------
// ftpp_parse_core
// parser state and the single-pass next-state and result logic per byte
// ---------------------------------------------------------------------------
`default_nettype none

module ftpp_parse_core #(
    parameter int unsigned SIZE_BYTES = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        link_byte,
    input  wire logic              end_of_frame,
    input  wire ftpp_pkg::cfg_t    cfg,
    output ftpp_pkg::result_t      result
);
    import ftpp_pkg::*;

    localparam int unsigned IDX_W = (SIZE_BYTES >= 3) ? $clog2(SIZE_BYTES + 1) : 2;

    // parse phases
    localparam logic [2:0] PH_KIND    = 3'd0;
    localparam logic [2:0] PH_HDR     = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_LEN     = 3'd4;
    localparam logic [2:0] PH_VALUE   = 3'd5;
    localparam logic [2:0] PH_SKIP    = 3'd6;

    logic [2:0]       phase_reg, phase_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       ftype_reg, ftype_next;
    logic [7:0]       left_reg, left_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      acc_reg, acc_next;
    logic [7:0]       seq_reg, seq_next;
    logic [15:0]      len_reg, len_next;
    logic [1:0]       hdr_reg, hdr_next;
    logic [2:0]       err_reg, err_next;
    logic [2:0]       cls;

    // per-byte next state
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        ftype_next = ftype_reg;
        left_next  = left_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        hdr_next   = hdr_reg;
        err_next   = err_reg;
        cls        = CLS_SKIP;

        case (phase_reg)
            PH_KIND:
            begin
                cls      = CLS_KIND;
                err_next = ERR_NONE;
                if (link_byte == cfg.data_code)
                begin
                    kind_next  = KIND_DATA;
                    seq_next   = 8'd0;
                    len_next   = 16'd0;
                    hdr_next   = 2'd0;
                    phase_next = PH_HDR;
                end
                else if (link_byte == cfg.start_code || link_byte == cfg.end_code)
                begin
                    kind_next  = (link_byte == cfg.start_code) ? KIND_START : KIND_END;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    kind_next  = KIND_UNKNOWN;
                    err_next   = ERR_UNKNOWN_KIND;
                    phase_next = PH_SKIP;
                end
            end
            PH_HDR:
            begin
                cls = CLS_HEADER;
                case (hdr_reg)
                    2'd0:    seq_next = link_byte;
                    2'd1:    len_next = {link_byte, 8'd0};
                    default: len_next = {len_reg[15:8], link_byte};
                endcase
                if (hdr_reg >= 2'd2)
                begin
                    hdr_next   = 2'd0;
                    phase_next = PH_PAYLOAD;
                end
                else
                begin
                    hdr_next = hdr_reg + 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                cls = CLS_PAYLOAD;
            end
            PH_TYPE:
            begin
                cls        = CLS_TL;
                ftype_next = link_byte;
                if (link_byte == cfg.size_field_code)
                begin
                    acc_next = 32'd0;
                    idx_next = '0;
                end
                else if (link_byte != cfg.name_field_code && err_next == ERR_NONE)
                begin
                    err_next = ERR_UNKNOWN_FIELD;
                end
                phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                cls       = CLS_TL;
                left_next = link_byte;
                if (ftype_reg == cfg.size_field_code && 32'(link_byte) > SIZE_BYTES
                    && err_next == ERR_NONE)
                begin
                    err_next = ERR_SIZE_OVERFLOW;
                end
                phase_next = (link_byte == 8'd0) ? PH_TYPE : PH_VALUE;
            end
            PH_VALUE:
            begin
                if (ftype_reg == cfg.size_field_code)
                begin
                    cls = CLS_SIZE;
                    if (32'(idx_reg) < SIZE_BYTES)
                    begin
                        if (32'(idx_reg) < 32'd4)
                        begin
                            acc_next = acc_reg |
                                ({24'd0, link_byte} << {idx_reg[1:0], 3'b000});
                        end
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                else if (ftype_reg == cfg.name_field_code)
                begin
                    cls = CLS_NAME;
                end
                else
                begin
                    cls = CLS_SKIP;
                end
                left_next = left_reg - 8'd1;
                if (left_next == 8'd0)
                begin
                    phase_next = PH_TYPE;
                end
            end
            default:
            begin
                cls = CLS_SKIP;
            end
        endcase

        // frame end: flag a cut field and rearm for a kind byte
        if (end_of_frame)
        begin
            if ((phase_next == PH_HDR || phase_next == PH_LEN || phase_next == PH_VALUE)
                && err_next == ERR_NONE)
            begin
                err_next = ERR_TRUNCATED;
            end
            phase_next = PH_KIND;
            hdr_next   = 2'd0;
            left_next  = 8'd0;
        end
    end

    // result of the current byte
    always_comb
    begin
        result.byte_class      = cls;
        result.byte_value      = link_byte;
        result.packet_kind     = kind_next;
        result.sequence_number = seq_next;
        result.declared_size   = len_next;
        result.file_size_value = acc_next;
        result.packet_done     = end_of_frame;
        result.error_code      = err_next;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KIND;
            kind_reg  <= KIND_DATA;
            ftype_reg <= 8'd0;
            left_reg  <= 8'd0;
            idx_reg   <= '0;
            acc_reg   <= 32'd0;
            seq_reg   <= 8'd0;
            len_reg   <= 16'd0;
            hdr_reg   <= 2'd0;
            err_reg   <= ERR_NONE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            ftype_reg <= ftype_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            seq_reg   <= seq_next;
            len_reg   <= len_next;
            hdr_reg   <= hdr_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ftpp_out_buf.sv -----
// ---------------------------------------------------------------------------
// ftpp_out_buf
// two-entry result queue separating the input and output handshakes
// ---------------------------------------------------------------------------
`default_nettype none

module ftpp_out_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ftpp_pkg::result_t    push_data,
    output logic                      can_push,
    input  wire logic                 pop,
    output logic                      head_valid,
    output ftpp_pkg::result_t         head_data
);
    import ftpp_pkg::*;

    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    logic [1:0] cnt_reg, cnt_next;

    assign can_push   = (cnt_reg != 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = e0_reg;

    // queue update
    always_comb
    begin
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    e0_next = push_data;
                end
                else
                begin
                    e1_next = push_data;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                e0_next  = e1_reg;
                cnt_next = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    e0_next = push_data;
                end
                else
                begin
                    e0_next = e1_reg;
                    e1_next = push_data;
                end
            end
            default: ;
        endcase
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // entries
    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

endmodule

`default_nettype wire

// ----- rtl/file_transfer_packet_parser.sv -----
// ---------------------------------------------------------------------------
// file_transfer_packet_parser
// byte-serial parser for data and tlv control packets of a file transfer
// ---------------------------------------------------------------------------
// Usage
//   Input channel: in_valid/in_ready carry one link byte and its end-of-frame
//   flag per request. Output channel: out_valid/out_ready carry one result per
//   input byte, in order: byte class, the byte, packet kind, sequence number,
//   declared size, accumulated file size, packet done and the packet error.
//   An accepted byte's result is registered into the queue and reaches the
//   outputs once earlier results are taken. Throughput: one byte per cycle
//   while in_ready is high, set by the one-pass parser state update per byte.
//   Stall: results collect in a two-entry queue; in_ready drops only when both
//   entries wait, and rises again once the receiver takes one.
//   Reset: rst_n clears the parser to expect a kind byte, empties the queue
//   and loads the default codes (data 1, start 2, end 3, size 0, name 1).
//   Configuration: APB writes at byte address 4*i, pready always high; write
//   only while no byte is in flight.
// ---------------------------------------------------------------------------
`default_nettype none

module file_transfer_packet_parser #(
    parameter int unsigned SIZE_BYTES = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ftpp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [7:0]                   link_byte,
    input  wire logic                         end_of_frame,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [2:0]                   byte_class,
    output logic      [7:0]                   byte_value,
    output logic      [1:0]                   packet_kind,
    output logic      [7:0]                   sequence_number,
    output logic      [15:0]                  declared_size,
    output logic      [31:0]                  file_size_value,
    output logic                              packet_done,
    output logic      [2:0]                   error_code
);
    import ftpp_pkg::*;

    cfg_t    cfg;
    result_t core_result;
    result_t head;
    logic    accept;

    assign accept = in_valid & in_ready;

    // configuration registers
    ftpp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // parser
    ftpp_parse_core #(
        .SIZE_BYTES (SIZE_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .link_byte    (link_byte),
        .end_of_frame (end_of_frame),
        .cfg          (cfg),
        .result       (core_result)
    );

    // result queue
    ftpp_out_buf u_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (core_result),
        .can_push   (in_ready),
        .pop        (out_valid & out_ready),
        .head_valid (out_valid),
        .head_data  (head)
    );

    // output fields
    assign byte_class      = head.byte_class;
    assign byte_value      = head.byte_value;
    assign packet_kind     = head.packet_kind;
    assign sequence_number = head.sequence_number;
    assign declared_size   = head.declared_size;
    assign file_size_value = head.file_size_value;
    assign packet_done     = head.packet_done;
    assign error_code      = head.error_code;

    // checks
    `include "file_transfer_packet_parser_assert.svh"

    `FTPP_ASSERT_NOW(a_kind_byte_err, out_valid && byte_class == CLS_KIND,
        error_code != ERR_UNKNOWN_FIELD && error_code != ERR_SIZE_OVERFLOW,
        "field error reported on a kind byte")
    `FTPP_ASSERT_NOW(a_unknown_skip,
        out_valid && packet_kind == KIND_UNKNOWN && byte_class != CLS_KIND,
        byte_class == CLS_SKIP && error_code == ERR_UNKNOWN_KIND,
        "unknown packet byte not skipped")
    `FTPP_ASSERT_NOW(a_full_has_head, !in_ready, out_valid,
        "input blocked with no result waiting")
    `FTPP_ASSERT_NEXT(a_accept_shows, accept && !out_valid, out_valid,
        "accepted byte gave no result")

endmodule

`default_nettype wire

// ----- tb/file_transfer_packet_parser_tb.sv -----
// ---------------------------------------------------------------------------
// file_transfer_packet_parser_tb
// drives link bytes through the packet parser and checks every byte result
// against a cycle-free model of the parse, under several sets of kind and
// field codes written over the register port, with random idling on both
// channels and a long receiver hold-off that fills the result queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module file_transfer_packet_parser_tb;

    import ftpp_pkg::*;

    localparam int unsigned SIZE_BYTES     = 4;
    localparam int unsigned ACC_BYTES      = 4;
    localparam int unsigned MAX_IDLE       = 17;
    localparam int unsigned HOLD_CYCLES    = 120;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES    = 8;

    typedef enum logic [2:0] {
        AWAIT_KIND,
        IN_HEADER,
        IN_PAYLOAD,
        AWAIT_TYPE,
        AWAIT_LENGTH,
        IN_VALUE,
        SKIP_PACKET
    } parse_phase_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          link_byte;
    logic                end_of_frame;
    logic                out_valid;
    logic                out_ready;
    logic [2:0]          byte_class;
    logic [7:0]          byte_value;
    logic [1:0]          packet_kind;
    logic [7:0]          sequence_number;
    logic [15:0]         declared_size;
    logic [31:0]         file_size_value;
    logic                packet_done;
    logic [2:0]          error_code;

    // model copy of the codes and of the parser state
    cfg_t          codes;
    parse_phase_t  phase;
    logic [1:0]    cur_kind;
    logic [7:0]    fld_type;
    logic [7:0]    value_left;
    logic [2:0]    size_idx;
    logic [31:0]   size_acc;
    logic [7:0]    seq_byte;
    logic [15:0]   decl_size;
    logic [1:0]    hdr_pos;
    logic [2:0]    pkt_error;

    result_t       predicted_bytes [$];
    result_t       want;

    int unsigned   fail_count        = 0;
    int unsigned   bytes_sent        = 0;
    int unsigned   results_seen      = 0;
    int unsigned   code_settings     = 1;
    int unsigned   rx_hold_request   = 0;
    bit            tx_gapless        = 1'b0;
    bit            tx_force_gapless  = 1'b0;

    file_transfer_packet_parser #(
        .SIZE_BYTES(SIZE_BYTES)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .link_byte       (link_byte),
        .end_of_frame    (end_of_frame),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .byte_class      (byte_class),
        .byte_value      (byte_value),
        .packet_kind     (packet_kind),
        .sequence_number (sequence_number),
        .declared_size   (declared_size),
        .file_size_value (file_size_value),
        .packet_done     (packet_done),
        .error_code      (error_code)
    );

    // clock
    always #2 clk = ~clk;

    // parser model
    task automatic reset_model();
        codes      = {DATA_CODE_RST, START_CODE_RST, END_CODE_RST, SIZE_CODE_RST,
                      NAME_CODE_RST};
        phase      = AWAIT_KIND;
        cur_kind   = KIND_DATA;
        fld_type   = 8'h00;
        value_left = 8'h00;
        size_idx   = 3'd0;
        size_acc   = 32'h0;
        seq_byte   = 8'h00;
        decl_size  = 16'h0;
        hdr_pos    = 2'd0;
        pkt_error  = ERR_NONE;
    endtask

    // only the first error of a packet is kept
    task automatic note_error(input logic [2:0] code);
        if (pkt_error == ERR_NONE)
            pkt_error = code;
    endtask

    task automatic parse_link_byte(input logic [7:0] b, input logic eof, output result_t r);
        logic [2:0] cls;
        cls = CLS_SKIP;
        case (phase)
            AWAIT_KIND:
            begin
                cls       = CLS_KIND;
                pkt_error = ERR_NONE;
                // data code wins over start, start over end
                if (b == codes.data_code)
                begin
                    cur_kind  = KIND_DATA;
                    seq_byte  = 8'h00;
                    decl_size = 16'h0;
                    hdr_pos   = 2'd0;
                    phase     = IN_HEADER;
                end
                else if (b == codes.start_code || b == codes.end_code)
                begin
                    cur_kind = (b == codes.start_code) ? KIND_START : KIND_END;
                    phase    = AWAIT_TYPE;
                end
                else
                begin
                    cur_kind = KIND_UNKNOWN;
                    note_error(ERR_UNKNOWN_KIND);
                    phase    = SKIP_PACKET;
                end
            end
            IN_HEADER:
            begin
                // sequence byte, then big-endian declared size
                cls = CLS_HEADER;
                if (hdr_pos == 2'd0)
                    seq_byte = b;
                else if (hdr_pos == 2'd1)
                    decl_size = {b, 8'h00};
                else
                    decl_size[7:0] = b;
                if (hdr_pos >= 2'd2)
                begin
                    hdr_pos = 2'd0;
                    phase   = IN_PAYLOAD;
                end
                else
                begin
                    hdr_pos = hdr_pos + 2'd1;
                end
            end
            IN_PAYLOAD:
            begin
                cls = CLS_PAYLOAD;
            end
            AWAIT_TYPE:
            begin
                // size code is matched before name code
                cls      = CLS_TL;
                fld_type = b;
                if (b == codes.size_field_code)
                begin
                    size_acc  = 32'h0;
                    size_idx  = 3'd0;
                end
                else if (b != codes.name_field_code)
                begin
                    note_error(ERR_UNKNOWN_FIELD);
                end
                phase = AWAIT_LENGTH;
            end
            AWAIT_LENGTH:
            begin
                cls        = CLS_TL;
                value_left = b;
                if (fld_type == codes.size_field_code && b > SIZE_BYTES)
                    note_error(ERR_SIZE_OVERFLOW);
                phase = (b == 8'h00) ? AWAIT_TYPE : IN_VALUE;
            end
            IN_VALUE:
            begin
                if (fld_type == codes.size_field_code)
                begin
                    // little-endian accumulate, excess bytes dropped
                    cls = CLS_SIZE;
                    if (size_idx < SIZE_BYTES)
                    begin
                        if (size_idx < ACC_BYTES)
                            size_acc = size_acc | (32'(b) << (8 * size_idx));
                        size_idx = size_idx + 3'd1;
                    end
                end
                else if (fld_type == codes.name_field_code)
                begin
                    cls = CLS_NAME;
                end
                else
                begin
                    cls = CLS_SKIP;
                end
                value_left = value_left - 8'd1;
                if (value_left == 8'h00)
                    phase = AWAIT_TYPE;
            end
            default:
            begin
                cls = CLS_SKIP;
            end
        endcase

        // frame end inside a header or field is a truncation
        if (eof)
        begin
            if (phase == IN_HEADER || phase == AWAIT_LENGTH || phase == IN_VALUE)
                note_error(ERR_TRUNCATED);
            phase      = AWAIT_KIND;
            hdr_pos    = 2'd0;
            value_left = 8'h00;
        end

        r.byte_class      = cls;
        r.byte_value      = b;
        r.packet_kind     = cur_kind;
        r.sequence_number = seq_byte;
        r.declared_size   = decl_size;
        r.file_size_value = size_acc;
        r.packet_done     = eof;
        r.error_code      = pkt_error;
    endtask

    // one byte request on the input channel, after a random gap unless sent gapless
    task automatic send_link_byte(input logic [7:0] value, input logic last);
        int unsigned gap;
        result_t     predicted;
        gap = tx_gapless ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        link_byte    <= value;
        end_of_frame <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        parse_link_byte(value, last, predicted);
        predicted_bytes.push_back(predicted);
        bytes_sent++;
    endtask

    // drop valid and wait for every outstanding result
    task automatic finish_burst();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predicted_bytes.size() != 0) @(posedge clk);
    endtask

    // register write, then read back over the same port
    task automatic write_code(input logic [2:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'h0, value})
        begin
            $display("%0t ns: register %0d read back mismatch, expected %0h, actual %0h",
                     $time, idx, {24'h0, value}, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DATA_CODE:  codes.data_code       = value;
            REG_START_CODE: codes.start_code      = value;
            REG_END_CODE:   codes.end_code        = value;
            REG_SIZE_CODE:  codes.size_field_code = value;
            REG_NAME_CODE:  codes.name_field_code = value;
            default: ;
        endcase
    endtask

    task automatic set_codes(input logic [7:0] d, input logic [7:0] s, input logic [7:0] e,
                             input logic [7:0] sz, input logic [7:0] nm);
        finish_burst();
        write_code(REG_DATA_CODE, d);
        write_code(REG_START_CODE, s);
        write_code(REG_END_CODE, e);
        write_code(REG_SIZE_CODE, sz);
        write_code(REG_NAME_CODE, nm);
        code_settings++;
    endtask

    // random packet: mostly well-formed, some cut short, some noise
    task automatic send_random_packet();
        logic [8:0]  pkt [$];
        logic [7:0]  ftype;
        int unsigned pick;
        int unsigned nfields;
        int unsigned len;
        int unsigned nbytes;
        int unsigned cut;
        bit          broken;
        pick       = $urandom_range(0, 9);
        broken     = ($urandom_range(0, 7) == 0);
        tx_gapless = tx_force_gapless || ($urandom_range(0, 3) == 0);
        if (pick <= 3)
        begin
            pkt.push_back({1'b0, codes.data_code});
            repeat (3) pkt.push_back({1'b0, 8'($urandom)});
            repeat ($urandom_range(0, 6)) pkt.push_back({1'b0, 8'($urandom)});
        end
        else if (pick <= 8)
        begin
            pkt.push_back({1'b0, $urandom_range(0, 1) ? codes.start_code : codes.end_code});
            nfields = $urandom_range(0, 3);
            for (int f = 0; f < nfields; f++)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    ftype = codes.size_field_code;
                    2:       ftype = codes.name_field_code;
                    default: ftype = 8'($urandom);
                endcase
                len    = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 255)
                                                     : $urandom_range(0, SIZE_BYTES + 2);
                nbytes = (len <= 12) ? len : $urandom_range(1, 6);
                pkt.push_back({1'b0, ftype});
                pkt.push_back({1'b0, 8'(len)});
                repeat (nbytes) pkt.push_back({1'b0, 8'($urandom)});
                // a long field is cut by the frame end
                if (nbytes < len)
                    break;
            end
        end
        else
        begin
            broken = 1'b0;
            repeat ($urandom_range(1, 6))
                pkt.push_back({1'($urandom_range(0, 2) == 0), 8'($urandom)});
        end
        if (broken && pkt.size() > 1)
        begin
            cut = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > cut) void'(pkt.pop_back());
        end
        foreach (pkt[i])
            send_link_byte(pkt[i][7:0], pkt[i][8] || (i == pkt.size() - 1));
    endtask

    task automatic run_random_packets(input int unsigned target);
        int unsigned first;
        first = bytes_sent;
        while (bytes_sent - first < target) send_random_packet();
        finish_burst();
    endtask

    // data packet with extreme header values and payload
    task automatic test_data_packet();
        tx_gapless = 1'b0;
        send_link_byte(DATA_CODE_RST, 1'b0);
        send_link_byte(8'hFF, 1'b0);
        send_link_byte(8'hFF, 1'b0);
        send_link_byte(8'h00, 1'b0);
        send_link_byte(8'hA5, 1'b0);
        send_link_byte(8'h00, 1'b1);
        // frame ending on the data kind byte
        send_link_byte(DATA_CODE_RST, 1'b1);
        finish_burst();
    endtask

    // start packet with full size field, name field and unknown field
    task automatic test_control_fields();
        send_link_byte(START_CODE_RST, 1'b0);
        send_link_byte(SIZE_CODE_RST, 1'b0);
        send_link_byte(8'd4, 1'b0);
        repeat (4) send_link_byte(8'hFF, 1'b0);
        send_link_byte(NAME_CODE_RST, 1'b0);
        send_link_byte(8'd1, 1'b0);
        send_link_byte(8'hC3, 1'b0);
        send_link_byte(8'h7F, 1'b0);
        send_link_byte(8'd1, 1'b0);
        send_link_byte(8'hAA, 1'b1);
        finish_burst();
    endtask

    // zero-length field, oversize size field cut short, unknown kind
    task automatic test_error_cases();
        send_link_byte(END_CODE_RST, 1'b0);
        send_link_byte(SIZE_CODE_RST, 1'b0);
        send_link_byte(8'd0, 1'b0);
        send_link_byte(SIZE_CODE_RST, 1'b0);
        send_link_byte(8'd5, 1'b0);
        send_link_byte(8'h11, 1'b0);
        send_link_byte(8'h22, 1'b1);
        send_link_byte(8'hFE, 1'b0);
        send_link_byte(8'h00, 1'b1);
        finish_burst();
    endtask

    task automatic test_default_random();
        run_random_packets(120);
    endtask

    task automatic test_extreme_codes();
        set_codes(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
        run_random_packets(45);
        set_codes(8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        run_random_packets(45);
    endtask

    // data shares the start code, size shares the name code
    task automatic test_shared_codes();
        set_codes(8'h80, 8'h80, 8'h81, 8'h80, 8'h80);
        run_random_packets(80);
    endtask

    task automatic test_random_codes();
        repeat (2)
        begin
            set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            run_random_packets(60);
        end
    endtask

    // receiver holds off while requests keep coming, then sender drains
    task automatic test_backpressure();
        tx_force_gapless = 1'b1;
        rx_hold_request  = HOLD_CYCLES;
        repeat (6) send_random_packet();
        tx_force_gapless = 1'b0;
        finish_burst();
        repeat (4) send_random_packet();
        finish_burst();
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (predicted_bytes.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, actual byte %0h",
                         $time, byte_value);
                fail_count++;
            end
            else
            begin
                want = predicted_bytes.pop_front();
                check_field("byte_class", want.byte_class, byte_class);
                check_field("byte_value", want.byte_value, byte_value);
                check_field("packet_kind", want.packet_kind, packet_kind);
                check_field("sequence_number", want.sequence_number, sequence_number);
                check_field("declared_size", want.declared_size, declared_size);
                check_field("file_size_value", want.file_size_value, file_size_value);
                check_field("packet_done", want.packet_done, packet_done);
                check_field("error_code", want.error_code, error_code);
            end
        end
    end

    // receiver: random stall per result, calm stretches, long hold on request
    initial
    begin
        int unsigned stall;
        int unsigned calm_left;
        calm_left = 0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_request > 0)
            begin
                stall           = rx_hold_request;
                rx_hold_request = 0;
            end
            else if (calm_left > 0)
            begin
                stall = 0;
                calm_left--;
            end
            else
            begin
                stall = $urandom_range(0, MAX_IDLE);
                if ($urandom_range(0, 15) == 0)
                    calm_left = 24;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // watchdog on cycles with no request moving on either channel
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = 32'h0;
        in_valid     = 1'b0;
        link_byte    = 8'h00;
        end_of_frame = 1'b0;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_data_packet();
        test_control_fields();
        test_error_cases();
        test_default_random();
        test_extreme_codes();
        test_shared_codes();
        test_random_codes();
        test_backpressure();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run: %0d link bytes sent, %0d results checked, %0d code settings",
                 bytes_sent, results_seen, code_settings);
        $display("Covered data and control packets, error cases and a full result queue");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
